FILE: rtl/sprd_pkg.sv
// Shared types and constants for the run-length sprite row decoder.
package sprd_pkg;

    localparam logic [1:0] MODE_CTRL = 2'd0;
    localparam logic [1:0] MODE_LIT  = 2'd1;
    localparam logic [1:0] MODE_DROP = 2'd2;
    localparam logic [1:0] MODE_DONE = 2'd3;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_FILL    = 2'd1;
    localparam logic [1:0] KIND_ROW_END = 2'd2;

    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;

    localparam logic [7:0] FILL_VALUE = 8'd255;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
        logic [7:0]  run_length;
        logic        out_of_bounds;
        logic        sprite_done;
    } result_t;

    typedef struct packed {
        logic [1:0]  decode_mode;
        logic [6:0]  literals_left;
        logic [8:0]  column;
        logic [7:0]  row;
        logic [15:0] row_base_address;
    } state_t;

    typedef struct packed {
        logic [7:0] sprite_width;
        logic [7:0] sprite_height;
    } config_t;

endpackage

FILE: rtl/sprd_decode.sv
// Next-state and result logic for one coded byte of the sprite decoder.
module sprd_decode (
    input  sprd_pkg::item_t   item,
    input  sprd_pkg::state_t  state,
    input  sprd_pkg::config_t cfg,
    output sprd_pkg::state_t  state_next,
    output logic              result_fire,
    output sprd_pkg::result_t result
);
    import sprd_pkg::*;

    state_t      cur;
    logic [8:0]  stride;
    logic [16:0] limit;
    logic [7:0]  write_len;
    logic [7:0]  write_value;
    logic [1:0]  write_kind;
    logic [16:0] start_full;
    logic [17:0] end_full;
    logic [8:0]  column_after;
    logic        reaches_width;
    logic        last_row;
    logic [8:0]  row_plus_one;

    always_comb
    begin
        if (item.kind)
        begin
            cur = '0;
        end
        else
        begin
            cur = state;
        end
    end

    assign stride        = ({1'b0, cfg.sprite_width} + 9'd7) & 9'h1F8;
    assign limit         = 17'(stride * cfg.sprite_height);
    assign start_full    = {1'b0, cur.row_base_address} + {8'd0, cur.column};
    assign end_full      = {1'b0, start_full} + {10'd0, write_len};
    assign column_after  = cur.column + {1'b0, write_len};
    assign reaches_width = column_after >= {1'b0, cfg.sprite_width};
    assign row_plus_one  = {1'b0, cur.row} + 9'd1;
    assign last_row      = row_plus_one >= {1'b0, cfg.sprite_height};

    always_comb
    begin
        if (cur.decode_mode == MODE_LIT)
        begin
            write_len   = 8'd1;
            write_value = item.data_byte;
            write_kind  = KIND_LITERAL;
        end
        else
        begin
            write_len   = 8'd0 - item.data_byte;
            write_value = FILL_VALUE;
            write_kind  = KIND_FILL;
        end
    end

    always_comb
    begin
        state_next  = cur;
        result_fire = 1'b0;
        result      = '0;
        unique case (cur.decode_mode)
            MODE_CTRL, MODE_DROP:
            begin
                if (cur.decode_mode == MODE_DROP || item.data_byte == 8'd0)
                begin
                    result_fire          = 1'b1;
                    result.result_kind   = KIND_ROW_END;
                    result.pixel_address = cur.row_base_address;
                    result.sprite_done   = last_row;
                    state_next.column        = '0;
                    state_next.literals_left = '0;
                    if (last_row)
                    begin
                        state_next.decode_mode = MODE_DONE;
                    end
                    else
                    begin
                        state_next.decode_mode      = MODE_CTRL;
                        state_next.row              = row_plus_one[7:0];
                        state_next.row_base_address = cur.row_base_address
                                                      + {7'd0, stride};
                    end
                end
                else if (!item.data_byte[7])
                begin
                    state_next.literals_left = item.data_byte[6:0];
                    state_next.decode_mode   = MODE_LIT;
                end
                else
                begin
                    result_fire          = 1'b1;
                    result.result_kind   = write_kind;
                    result.pixel_address = start_full[15:0];
                    result.pixel_value   = write_value;
                    result.run_length    = write_len;
                    result.out_of_bounds = end_full > {1'b0, limit};
                    state_next.column      = column_after;
                    state_next.decode_mode = reaches_width ? MODE_DROP : MODE_CTRL;
                end
            end
            MODE_LIT:
            begin
                result_fire          = 1'b1;
                result.result_kind   = write_kind;
                result.pixel_address = start_full[15:0];
                result.pixel_value   = write_value;
                result.run_length    = write_len;
                result.out_of_bounds = end_full > {1'b0, limit};
                state_next.column        = column_after;
                state_next.literals_left = cur.literals_left - 7'd1;
                if (cur.literals_left == 7'd1)
                begin
                    state_next.decode_mode = reaches_width ? MODE_DROP : MODE_CTRL;
                end
            end
            MODE_DONE:
            begin
                result_fire = 1'b0;
            end
            default:
            begin
                result_fire = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/sprite_rle_row_decoder.sv
// Top level of the run-length sprite row decoder: handshakes, registers and configuration.
// The decoder takes one coded byte per transaction and gives at most one pixel write,
// fill run or row end for it. A byte sits in the input register while the
// decode logic works on it, and its result is registered in the output register once
// that register is empty or being taken; one byte is accepted every cycle as long
// as the output register is empty or being taken in the same cycle.
module sprite_rle_row_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  sprd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output sprd_pkg::result_t result,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import sprd_pkg::*;

    logic     item_valid_reg;
    item_t    item_reg;
    state_t   state_reg;
    state_t   state_next;
    config_t  cfg_reg;
    logic     result_valid_reg;
    result_t  result_reg;
    logic     advance;
    logic     fire;
    result_t  decoded;

    assign advance      = !result_valid_reg || result_ready;
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    sprd_decode u_decode (
        .item        (item_reg),
        .state       (state_reg),
        .cfg         (cfg_reg),
        .state_next  (state_next),
        .result_fire (fire),
        .result      (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_width  <= 8'd1;
            cfg_reg.sprite_height <= 8'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  cfg_reg.sprite_width  <= cfg_data;
                REG_HEIGHT: cfg_reg.sprite_height <= cfg_data;
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= item_valid_reg && fire;
                if (item_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance && item_valid_reg && fire)
        begin
            result_reg <= decoded;
        end
    end

endmodule

FILE: verif/sprd_checker.sv
// Checker for the sprite row decoder: predicts the result of each input transaction and compares.
module sprd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  sprd_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  sprd_pkg::result_t result,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    output int                mismatches,
    output int                writes_due
);
    import sprd_pkg::*;

    state_t  st;
    config_t cfg;
    result_t predicted_writes[$];

    function automatic logic [8:0] stride_now();
        return ({1'b0, cfg.sprite_width} + 9'd7) & 9'h1F8;
    endfunction

    function automatic result_t run_write(input logic [1:0] k, input logic [7:0] value,
                                          input logic [8:0] len);
        int unsigned start_addr;
        int unsigned surface_end;
        result_t     r;
        start_addr = st.row_base_address + st.column;
        surface_end = stride_now() * cfg.sprite_height;
        r.result_kind = k;
        r.pixel_address = start_addr[15:0];
        r.pixel_value = value;
        r.run_length = len[7:0];
        r.out_of_bounds = (start_addr + len > surface_end);
        r.sprite_done = 1'b0;
        st.column = st.column + len;
        return r;
    endfunction

    function automatic void end_of_run();
        st.decode_mode = (st.column >= cfg.sprite_width) ? MODE_DROP : MODE_CTRL;
    endfunction

    function automatic result_t row_end();
        result_t r;
        logic    final_row;
        final_row = (st.row + 9'd1 >= cfg.sprite_height);
        r = '0;
        r.result_kind = KIND_ROW_END;
        r.pixel_address = st.row_base_address;
        r.sprite_done = final_row;
        if (final_row)
        begin
            st.decode_mode = MODE_DONE;
        end
        else
        begin
            st.row = st.row + 8'd1;
            st.row_base_address = st.row_base_address + stride_now();
            st.decode_mode = MODE_CTRL;
        end
        st.column = '0;
        st.literals_left = '0;
        return r;
    endfunction

    // Returns 1 when the byte produces a surface write or a row end.
    function automatic logic decode_byte(input item_t it, output result_t r);
        logic [7:0] b;
        b = it.data_byte;
        r = '0;
        if (it.kind)
        begin
            st = '0;
        end
        case (st.decode_mode)
            MODE_CTRL:
            begin
                if (b == 8'd0)
                begin
                    r = row_end();
                    return 1'b1;
                end
                if (b < 8'd128)
                begin
                    st.literals_left = b[6:0];
                    st.decode_mode = MODE_LIT;
                    return 1'b0;
                end
                r = run_write(KIND_FILL, FILL_VALUE, 9'd256 - b);
                end_of_run();
                return 1'b1;
            end
            MODE_LIT:
            begin
                r = run_write(KIND_LITERAL, b, 9'd1);
                st.literals_left = st.literals_left - 7'd1;
                if (st.literals_left == 7'd0)
                begin
                    end_of_run();
                end
                return 1'b1;
            end
            MODE_DROP:
            begin
                r = row_end();
                return 1'b1;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic int field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            st = '0;
            cfg.sprite_width = 8'd1;
            cfg.sprite_height = 8'd1;
            predicted_writes.delete();
            writes_due <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (predicted_writes.size() == 0)
                begin
                    $display("%0t: expected no transaction, got result %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = predicted_writes.pop_front();
                    mismatches += field_diff("result_kind", want.result_kind,
                                             result.result_kind)
                                + field_diff("pixel_address", want.pixel_address,
                                             result.pixel_address)
                                + field_diff("pixel_value", want.pixel_value,
                                             result.pixel_value)
                                + field_diff("run_length", want.run_length,
                                             result.run_length)
                                + field_diff("out_of_bounds", want.out_of_bounds,
                                             result.out_of_bounds)
                                + field_diff("sprite_done", want.sprite_done,
                                             result.sprite_done);
                end
            end
            if (item_valid && item_ready)
            begin
                if (decode_byte(item, predicted))
                begin
                    predicted_writes.push_back(predicted);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    cfg.sprite_width = cfg_data;
                end
                else
                begin
                    cfg.sprite_height = cfg_data;
                end
            end
            writes_due <= predicted_writes.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the sprite row decoder testbench: clock, reset, stimulus, handshakes and verdict.
module testbench;
    import sprd_pkg::*;

    localparam logic BYTE_NEXT   = 1'b0;
    localparam logic BYTE_START  = 1'b1;
    localparam int   IDLE_LIMIT  = 5000;
    localparam int   ITEM_TARGET = 1450;
    localparam int   PHASE_BYTES = 100;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    item_t      item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;
    logic       cfg_write = 1'b0;
    logic       cfg_index = REG_WIDTH;
    logic [7:0] cfg_data = 8'd0;
    int         mismatches;
    int         writes_due;
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;
    int         stall_count = 0;
    logic [7:0] width_now = 8'd1;
    logic [7:0] height_now = 8'd1;
    logic       sprite_start = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sprite_rle_row_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sprd_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .writes_due   (writes_due)
    );

    always @(posedge clk)
    begin
        stall_count <= stall_count + 1;
        case ((stall_count / 97) % 4)
            0: result_ready <= 1'b1;
            1: result_ready <= ($urandom_range(0, 1) == 1);
            2: result_ready <= ((stall_count % 5) < 3);
            default: result_ready <= ((stall_count % 23) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_byte(input logic k, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 6);
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= '{kind: k, data_byte: b};
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        bytes_sent++;
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(sprite_start ? BYTE_START : BYTE_NEXT, b);
        sprite_start = 1'b0;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (writes_due != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] w, input logic [7:0] h);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        width_now = w;
        height_now = h;
    endtask

    // Well-formed rows: runs until the width is reached, then a dropped byte, or an early zero.
    task automatic gen_sprite(input int rows_max, input int stop_at);
        int   rows;
        int   col;
        int   run;
        logic ended;
        rows = (height_now == 8'd0) ? 1 : height_now;
        if (rows > rows_max)
        begin
            rows = rows_max;
        end
        for (int r = 0; r < rows && bytes_sent < stop_at; r++)
        begin
            col = 0;
            ended = 1'b0;
            do
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    put_byte(8'd0);
                    ended = 1'b1;
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128)
                                                      : $urandom_range(1, 8);
                    put_byte(8'(256 - run));
                    col += run;
                end
                else
                begin
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127)
                                                      : $urandom_range(1, 6);
                    put_byte(8'(run));
                    repeat (run) put_byte(8'($urandom));
                    col += run;
                end
            end
            while (!ended && col < width_now);
            if (!ended)
            begin
                put_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        int phase;
        int stop_at;
        int pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decoding straight after reset with the reset width and height of one.
        send_byte(BYTE_NEXT, 8'h01);
        send_byte(BYTE_NEXT, 8'h00);
        send_byte(BYTE_NEXT, 8'hFF);
        send_byte(BYTE_NEXT, 8'h55);
        send_byte(BYTE_START, 8'h80);
        send_byte(BYTE_NEXT, 8'h7F);
        send_byte(BYTE_START, 8'h00);

        write_config(8'd255, 8'd2);
        send_byte(BYTE_START, 8'h81);
        send_byte(BYTE_NEXT, 8'h80);
        send_byte(BYTE_NEXT, 8'h00);
        send_byte(BYTE_NEXT, 8'h02);
        send_byte(BYTE_NEXT, 8'hFF);
        send_byte(BYTE_NEXT, 8'hAA);
        send_byte(BYTE_NEXT, 8'h00);

        write_config(8'd0, 8'd0);
        send_byte(BYTE_START, 8'hFF);
        send_byte(BYTE_NEXT, 8'h12);
        send_byte(BYTE_START, 8'h7F);
        send_byte(BYTE_NEXT, 8'h01);
        send_byte(BYTE_START, 8'h00);

        phase = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            case (phase)
                0: write_config(8'd8, 8'd4);
                1: write_config(8'd1, 8'd255);
                2: write_config(8'd16, 8'd2);
                3: write_config(8'd255, 8'd255);
                4: write_config(8'd0, 8'd3);
                5: write_config(8'd5, 8'd0);
                6: write_config(8'd255, 8'd1);
                default:
                begin
                    write_config(($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(1, 24)),
                                 ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                             : 8'($urandom_range(1, 6)));
                end
            endcase
            stop_at = bytes_sent + PHASE_BYTES;
            // Some phases carry on the unfinished sprite under the new height.
            sprite_start = !(phase == 2 || (phase > 6 && $urandom_range(0, 3) == 0));
            while (bytes_sent < stop_at)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    gen_sprite(256, stop_at);
                end
                else if (pick == 8)
                begin
                    repeat ($urandom_range(1, 10))
                        send_byte(($urandom_range(0, 7) == 0) ? BYTE_START : BYTE_NEXT,
                                  8'($urandom));
                end
                else
                begin
                    gen_sprite($urandom_range(1, 2), stop_at);
                end
                sprite_start = 1'b1;
            end
            phase++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sprd_pkg.sv
rtl/sprd_decode.sv
rtl/sprite_rle_row_decoder.sv
verif/sprd_checker.sv
verif/testbench.sv
